[design/ethernet_tx_pause_controller_unit_defines.svh]
// Assertion macros shared by the transmit pause controller modules.
`ifndef ETHERNET_TX_PAUSE_CONTROLLER_UNIT_DEFINES_SVH
`define ETHERNET_TX_PAUSE_CONTROLLER_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define ETPC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that, when true, implies a consequence in the same cycle.
`define ETPC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that, when true, implies a consequence in the next cycle.
`define ETPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/etpc_pkg.sv]
// Shared types, constants and helper functions of the transmit pause controller.
package etpc_pkg;

    localparam int unsigned DEFAULT_QUEUE_DEPTH = 16;

    localparam int unsigned LEN_W       = 11;
    localparam int unsigned UNITS_W     = 16;
    localparam int unsigned COUNTDOWN_W = 26;
    localparam int unsigned COUNT_W     = 5;

    localparam logic [LEN_W-1:0] MIN_FRAME_BYTES    = 11'd64;
    localparam logic [LEN_W-1:0] MAX_FRAME_BYTES    = 11'd1518;
    localparam logic [LEN_W-1:0] PREAMBLE_SFD_BYTES = 11'd8;
    localparam logic [COUNTDOWN_W-1:0] IFG_TICKS    = 26'd96;
    // One pause quantum is 512 bit times, a shift by nine.
    localparam int unsigned PAUSE_QUANTUM_SHIFT = 9;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_TX    = 2'd1,
        MODE_IFG   = 2'd2,
        MODE_PAUSE = 2'd3
    } etpc_mode_t;

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_FRAME  = 2'd1,
        FUNC_PAUSE  = 2'd2,
        FUNC_UNUSED = 2'd3
    } etpc_func_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_LINK_DOWN = 2'd1,
        STATUS_OVERSIZE  = 2'd2,
        STATUS_FULL      = 2'd3
    } etpc_status_t;

    typedef enum logic {
        CFG_LINK_UP     = 1'b0,
        CFG_QUEUE_LIMIT = 1'b1
    } etpc_cfg_index_t;

    // Queue command from the controller to the frame queue.
    typedef struct packed {
        logic             push;
        logic             pop;
        logic [LEN_W-1:0] wdata;
    } etpc_qcmd_t;

    // One result item.
    typedef struct packed {
        logic [COUNT_W-1:0] queue_count;
        etpc_status_t       status;
        logic               tx_done;
        logic [LEN_W-1:0]   tx_wire_bytes;
        logic               tx_start;
        etpc_mode_t         tx_state;
    } etpc_result_t;

    // Ticks of a pause of the given number of quanta.
    function automatic logic [COUNTDOWN_W-1:0] pause_ticks(input logic [UNITS_W-1:0] units);
        pause_ticks = COUNTDOWN_W'({units, {PAUSE_QUANTUM_SHIFT{1'b0}}});
    endfunction

    // Ticks of a frame on the wire, eight per byte.
    function automatic logic [COUNTDOWN_W-1:0] wire_ticks(input logic [LEN_W-1:0] bytes);
        wire_ticks = COUNTDOWN_W'({bytes, 3'b000});
    endfunction

endpackage

[design/etpc_queue.sv]
// Frame length queue: one synchronous memory with head prefetch and write forwarding.
`include "ethernet_tx_pause_controller_unit_defines.svh"

module etpc_queue #(
    parameter int unsigned QUEUE_DEPTH = etpc_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  etpc_pkg::etpc_qcmd_t                       qcmd,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]           fill,
    output logic [etpc_pkg::LEN_W-1:0]                 head_data
);
    import etpc_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH+1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

    logic [LEN_W-1:0]  mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [LEN_W-1:0]  rd_data_reg;

    // Pointer and fill updates.
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (qcmd.pop)
        begin
            head_next = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
        end
        if (qcmd.push)
        begin
            tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
        end
        fill_next = fill_reg + FILL_W'(qcmd.push) - FILL_W'(qcmd.pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    // Memory write at the tail.
    always_ff @(posedge clk)
    begin
        if (qcmd.push)
        begin
            mem[tail_reg] <= qcmd.wdata;
        end
    end

    // Read the next head; a write to the same entry in this cycle is forwarded.
    always_ff @(posedge clk)
    begin
        if (qcmd.push && (tail_reg == head_next))
        begin
            rd_data_reg <= qcmd.wdata;
        end
        else
        begin
            rd_data_reg <= mem[head_next];
        end
    end

    assign fill      = fill_reg;
    assign head_data = rd_data_reg;

    `ETPC_ASSERT_ALWAYS(a_fill_bound, fill_reg <= FILL_MAX, "queue fill above depth")
    `ETPC_ASSERT_SAME(a_no_overflow, qcmd.push && !qcmd.pop, fill_reg < FILL_MAX,
        "push into a full queue")
    `ETPC_ASSERT_SAME(a_no_underflow, qcmd.pop, (fill_reg != '0) || qcmd.push,
        "pop from an empty queue")

endmodule

[design/etpc_ctrl.sv]
// Transmit state machine, pause handling and configuration registers.
`include "ethernet_tx_pause_controller_unit_defines.svh"

module etpc_ctrl #(
    parameter int unsigned QUEUE_DEPTH = etpc_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_fire,
    input  etpc_pkg::etpc_func_t                  func,
    input  logic [etpc_pkg::LEN_W-1:0]            frame_length,
    input  logic [etpc_pkg::UNITS_W-1:0]          pause_units,
    input  logic                                  cfg_wr_en,
    input  etpc_pkg::etpc_cfg_index_t             cfg_index,
    input  logic [etpc_pkg::COUNT_W-1:0]          cfg_data,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]      fill,
    input  logic [etpc_pkg::LEN_W-1:0]            head_data,
    output etpc_pkg::etpc_qcmd_t                  qcmd,
    output etpc_pkg::etpc_result_t                result
);
    import etpc_pkg::*;

    localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH+1);
    localparam int unsigned CMP_W = (FILL_W > COUNT_W) ? FILL_W : COUNT_W;
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

    etpc_mode_t                mode_reg, mode_next;
    logic [COUNTDOWN_W-1:0]    countdown_reg, countdown_next;
    logic [UNITS_W-1:0]        pending_reg, pending_next;
    logic                      link_up_reg;
    logic [COUNT_W-1:0]        queue_limit_reg;

    logic [LEN_W-1:0]          padded_len;
    logic [LEN_W-1:0]          pop_len;
    logic [LEN_W-1:0]          wire_bytes;
    logic                      queue_full;
    logic                      start_next;
    logic [FILL_W-1:0]         fill_after;

    // Padding, queue limit and the length of the frame that would start next.
    always_comb
    begin
        padded_len = (frame_length < MIN_FRAME_BYTES) ? MIN_FRAME_BYTES : frame_length;
        queue_full = (CMP_W'(fill) >= CMP_W'(queue_limit_reg)) || (fill >= FILL_MAX);
        pop_len    = (fill == '0) ? padded_len : head_data;
        wire_bytes = pop_len + PREAMBLE_SFD_BYTES;
    end

    // Next state and result of the item at the input.
    always_comb
    begin
        mode_next      = mode_reg;
        countdown_next = countdown_reg;
        pending_next   = pending_reg;
        qcmd           = '0;
        qcmd.wdata     = padded_len;
        start_next     = 1'b0;
        result         = '0;
        result.status  = STATUS_OK;

        case (func)
            FUNC_TICK:
            begin
                if (mode_reg != MODE_IDLE)
                begin
                    if (countdown_reg <= COUNTDOWN_W'(1))
                    begin
                        countdown_next = '0;
                        if (mode_reg == MODE_TX)
                        begin
                            result.tx_done = 1'b1;
                            if (pending_reg != '0)
                            begin
                                countdown_next = pause_ticks(pending_reg);
                                mode_next      = MODE_PAUSE;
                                pending_next   = '0;
                            end
                            else
                            begin
                                countdown_next = IFG_TICKS;
                                mode_next      = MODE_IFG;
                            end
                        end
                        else if ((mode_reg == MODE_IFG) && (pending_reg != '0))
                        begin
                            countdown_next = pause_ticks(pending_reg);
                            mode_next      = MODE_PAUSE;
                            pending_next   = '0;
                        end
                        else
                        begin
                            start_next = 1'b1;
                        end
                    end
                    else
                    begin
                        countdown_next = countdown_reg - 1'b1;
                    end
                end
            end
            FUNC_FRAME:
            begin
                if (padded_len > MAX_FRAME_BYTES)
                begin
                    result.status = STATUS_OVERSIZE;
                end
                else if (!link_up_reg)
                begin
                    result.status = STATUS_LINK_DOWN;
                end
                else if (queue_full)
                begin
                    result.status = STATUS_FULL;
                end
                else
                begin
                    qcmd.push  = 1'b1;
                    start_next = (mode_reg == MODE_IDLE);
                end
            end
            FUNC_PAUSE:
            begin
                if ((mode_reg == MODE_IDLE) || (mode_reg == MODE_PAUSE))
                begin
                    if (pause_units != '0)
                    begin
                        countdown_next = pause_ticks(pause_units);
                        mode_next      = MODE_PAUSE;
                    end
                    else if (mode_reg == MODE_PAUSE)
                    begin
                        start_next = 1'b1;
                    end
                end
                else
                begin
                    pending_next = pause_units;
                end
            end
            default:
            begin
                // Unused code: nothing changes.
            end
        endcase

        // Start the head frame or go idle.
        if (start_next)
        begin
            if ((fill != '0) || qcmd.push)
            begin
                qcmd.pop             = 1'b1;
                result.tx_start      = 1'b1;
                result.tx_wire_bytes = wire_bytes;
                countdown_next       = wire_ticks(wire_bytes);
                mode_next            = MODE_TX;
            end
            else
            begin
                countdown_next = '0;
                mode_next      = MODE_IDLE;
            end
        end

        // The queue acts only on an accepted item.
        if (!in_fire)
        begin
            qcmd.push = 1'b0;
            qcmd.pop  = 1'b0;
        end

        fill_after         = fill + FILL_W'(qcmd.push) - FILL_W'(qcmd.pop);
        result.tx_state    = mode_next;
        result.queue_count = COUNT_W'(fill_after);
    end

    // State registers advance on each transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            countdown_reg <= '0;
            pending_reg   <= '0;
        end
        else if (in_fire)
        begin
            mode_reg      <= mode_next;
            countdown_reg <= countdown_next;
            pending_reg   <= pending_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_up_reg     <= 1'b1;
            queue_limit_reg <= COUNT_W'(16);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_LINK_UP:     link_up_reg     <= cfg_data[0];
                CFG_QUEUE_LIMIT: queue_limit_reg <= cfg_data;
                default:         link_up_reg     <= link_up_reg;
            endcase
        end
    end

    `ETPC_ASSERT_SAME(a_idle_quiet, mode_reg == MODE_IDLE,
        (fill == '0) && (countdown_reg == '0), "idle with queued frames or a running count")
    `ETPC_ASSERT_SAME(a_pending_busy, pending_reg != '0,
        (mode_reg == MODE_TX) || (mode_reg == MODE_IFG), "held pause outside a transmission")
    `ETPC_ASSERT_NEXT(a_start_enters_tx, in_fire && result.tx_start, mode_reg == MODE_TX,
        "frame start did not enter transmission")

endmodule

[design/etpc_skid.sv]
// Two-entry output stage: a result register with a skid register behind it.
module etpc_skid (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  etpc_pkg::etpc_result_t in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output etpc_pkg::etpc_result_t out_data
);
    import etpc_pkg::*;

    logic         out_valid_reg;
    logic         skid_valid_reg;
    etpc_result_t out_data_reg;
    etpc_result_t skid_data_reg;
    logic         in_fire;
    logic         out_free;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || in_fire;
            skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        else if (in_fire)
        begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[design/ethernet_tx_pause_controller_unit.sv]
// Top level of the full-duplex transmit controller with pause flow control.
//
//  Channel   Direction  Handshake            Content
//  s_*       in         s_tvalid / s_tready  tick, frame length or received pause
//  m_*       out        m_tvalid / m_tready  state, start, wire bytes, done, status, count
//  cfg_*     in         cfg_wr_en            link_up, queue_limit writes
//
// One item per cycle while s_tready is high: every input item is resolved in the cycle of its
// transfer, with the queue head prefetched into a register from the frame memory.
// The result of an item is held in the result register, or in the skid register while m_* stalls.
// s_tready drops only when both the result register and the skid register are full.
// Reset clears the state, the queue pointers and the output stage; no clearing pass.
module ethernet_tx_pause_controller_unit #(
    parameter int unsigned QUEUE_DEPTH = etpc_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // frame_length[10:0], pause_units[26:11], zeros above
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // tx_state[1:0], tx_start[2], tx_wire_bytes[13:3],
                                   // tx_done[14], status[16:15], queue_count[21:17], zeros
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data
);
    import etpc_pkg::*;

    localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH+1);

    logic              in_fire;
    etpc_qcmd_t        qcmd;
    etpc_result_t      result;
    etpc_result_t      out_result;
    logic [FILL_W-1:0] fill;
    logic [LEN_W-1:0]  head_data;

    assign in_fire = s_tvalid && s_tready;

    etpc_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .qcmd      (qcmd),
        .fill      (fill),
        .head_data (head_data)
    );

    etpc_ctrl #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (in_fire),
        .func         (etpc_func_t'(s_tuser)),
        .frame_length (s_tdata[LEN_W-1:0]),
        .pause_units  (s_tdata[LEN_W+UNITS_W-1:LEN_W]),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (etpc_cfg_index_t'(cfg_index)),
        .cfg_data     (cfg_data),
        .fill         (fill),
        .head_data    (head_data),
        .qcmd         (qcmd),
        .result       (result)
    );

    etpc_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    // The result struct is packed with its first field at the top.
    assign m_tdata = {2'b00, out_result};

endmodule

[tb/ethernet_tx_pause_controller_unit_tb.sv]
// Self-checking testbench for the transmit pause controller: random ticks, frames and pauses.
module ethernet_tx_pause_controller_unit_tb;
    import etpc_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEFAULT_QUEUE_DEPTH);

    // Shadow of the controller: tracks its state and queues the report expected per item.
    class tx_pause_shadow;
        etpc_mode_t             mode;
        logic [COUNTDOWN_W-1:0] countdown;
        logic [UNITS_W-1:0]     held_quanta;
        logic [LEN_W-1:0]       frame_lens[DEFAULT_QUEUE_DEPTH];
        logic [PTR_W-1:0]       rd_ptr;
        logic [PTR_W-1:0]       wr_ptr;
        logic [COUNT_W-1:0]     fill;
        logic                   link_up;
        logic [COUNT_W-1:0]     queue_limit;
        etpc_result_t           outcome;
        etpc_result_t           pending_tx_reports[$];
        int                     mismatch_count;
        int                     reports_seen;

        function new();
            mode = MODE_IDLE;
            countdown = '0;
            held_quanta = '0;
            rd_ptr = '0;
            wr_ptr = '0;
            fill = '0;
            link_up = 1'b1;
            queue_limit = COUNT_W'(DEFAULT_QUEUE_DEPTH);
            mismatch_count = 0;
            reports_seen = 0;
            foreach (frame_lens[i])
                frame_lens[i] = '0;
        endfunction

        function void write_reg(etpc_cfg_index_t idx, logic [COUNT_W-1:0] value);
            if (idx == CFG_LINK_UP)
                link_up = value[0];
            else
                queue_limit = value;
        endfunction

        // Start the head frame of the queue, or fall back to idle when it is empty.
        function void launch_next();
            if (fill != 0)
            begin
                outcome.tx_start = 1'b1;
                outcome.tx_wire_bytes = frame_lens[rd_ptr] + PREAMBLE_SFD_BYTES;
                countdown = COUNTDOWN_W'(outcome.tx_wire_bytes) << 3;
                rd_ptr++;
                fill--;
                mode = MODE_TX;
            end
            else
            begin
                countdown = '0;
                mode = MODE_IDLE;
            end
        endfunction

        function void start_pause(logic [UNITS_W-1:0] quanta);
            countdown = COUNTDOWN_W'(quanta) << PAUSE_QUANTUM_SHIFT;
            mode = MODE_PAUSE;
        endfunction

        // The running period has run out: move on to the gap, a held pause, the next frame or idle.
        function void close_period();
            if (mode == MODE_TX)
            begin
                outcome.tx_done = 1'b1;
                if (held_quanta != 0)
                begin
                    start_pause(held_quanta);
                    held_quanta = '0;
                end
                else
                begin
                    countdown = IFG_TICKS;
                    mode = MODE_IFG;
                end
            end
            else if (mode == MODE_IFG && held_quanta != 0)
            begin
                start_pause(held_quanta);
                held_quanta = '0;
            end
            else
                launch_next();
        endfunction

        // Apply one accepted input transfer and queue the report it must produce.
        function void advance_on_item(etpc_func_t func, logic [LEN_W-1:0] flen,
                                      logic [UNITS_W-1:0] quanta);
            logic [LEN_W-1:0]   padded;
            logic [COUNT_W-1:0] cap;
            outcome = '0;
            case (func)
                FUNC_TICK:
                begin
                    if (mode != MODE_IDLE)
                    begin
                        if (countdown <= 1)
                        begin
                            countdown = '0;
                            close_period();
                        end
                        else
                            countdown--;
                    end
                end
                FUNC_FRAME:
                begin
                    cap = (queue_limit < COUNT_W'(DEFAULT_QUEUE_DEPTH)) ?
                          queue_limit : COUNT_W'(DEFAULT_QUEUE_DEPTH);
                    padded = (flen < MIN_FRAME_BYTES) ? MIN_FRAME_BYTES : flen;
                    // Oversize wins over link down, which wins over a full queue.
                    if (padded > MAX_FRAME_BYTES)
                        outcome.status = STATUS_OVERSIZE;
                    else if (!link_up)
                        outcome.status = STATUS_LINK_DOWN;
                    else if (fill >= cap)
                        outcome.status = STATUS_FULL;
                    else
                    begin
                        frame_lens[wr_ptr] = padded;
                        wr_ptr++;
                        fill++;
                        if (mode == MODE_IDLE)
                            launch_next();
                    end
                end
                FUNC_PAUSE:
                begin
                    if (mode == MODE_IDLE)
                    begin
                        if (quanta != 0)
                            start_pause(quanta);
                    end
                    else if (mode == MODE_PAUSE)
                    begin
                        // A zero count ends the pause at once.
                        if (quanta != 0)
                            start_pause(quanta);
                        else
                            launch_next();
                    end
                    else
                        held_quanta = quanta;
                end
                default:
                    ;
            endcase
            outcome.tx_state = mode;
            outcome.queue_count = fill;
            pending_tx_reports.push_back(outcome);
        endfunction

        task report_mismatch(string msg);
            mismatch_count++;
            $display("ERROR: %s", msg);
        endtask

        task compare_field(string field, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report_mismatch($sformatf("report %0d: %s is %0d, expected %0d",
                                          reports_seen, field, got, want));
        endtask

        // Compare one output transfer with the oldest outstanding report.
        task check_report(logic [23:0] word);
            etpc_result_t got;
            etpc_result_t want;
            got = word[21:0];
            reports_seen++;
            if (pending_tx_reports.size() == 0)
            begin
                report_mismatch($sformatf("report %0d arrived with none outstanding",
                                          reports_seen));
                return;
            end
            want = pending_tx_reports.pop_front();
            compare_field("tx_state", got.tx_state, want.tx_state);
            compare_field("tx_start", got.tx_start, want.tx_start);
            compare_field("tx_wire_bytes", got.tx_wire_bytes, want.tx_wire_bytes);
            compare_field("tx_done", got.tx_done, want.tx_done);
            compare_field("status", got.status, want.status);
            compare_field("queue_count", got.queue_count, want.queue_count);
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = FUNC_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = CFG_LINK_UP;
    logic [4:0]  cfg_data = '0;

    tx_pause_shadow shadow;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_left = 0;
    int items_sent = 0;

    // Per phase: transfers, sender idle and receiver stall percentages, registers, hold-off.
    int phase_items[5]    = '{40, 20, 20, 30, 10};
    int phase_tx_idle[5]  = '{0, 88, 0, 16, 16};
    int phase_rx_stall[5] = '{0, 0, 88, 16, 0};
    int phase_link[5]     = '{1, 1, 1, 1, 0};
    int phase_limit[5]    = '{16, 1, 31, 8, 0};
    int phase_hold[5]     = '{1, 0, 0, 1, 0};

    ethernet_tx_pause_controller_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Offer one item, idling first at random, and return at the edge of its transfer.
    task automatic send_item(input etpc_func_t func, input logic [LEN_W-1:0] flen,
                             input logic [UNITS_W-1:0] quanta);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {5'd0, quanta, flen};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        shadow.advance_on_item(func, flen, quanta);
        items_sent++;
    endtask

    task automatic send_ticks(input int count);
        for (int k = 0; k < count; k++)
            send_item(FUNC_TICK, LEN_W'($urandom), UNITS_W'($urandom));
    endtask

    // Stop offering and wait until every outstanding report has come back.
    task automatic drain_reports();
        s_tvalid <= 1'b0;
        while (shadow.pending_tx_reports.size() != 0)
            @(posedge clk);
    endtask

    // Write both registers on back-to-back edges; only bit 0 of the link word counts.
    task automatic write_regs(input logic link, input logic [COUNT_W-1:0] limit);
        logic [4:0] link_word;
        link_word = {4'($urandom), link};
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_LINK_UP;
        cfg_data  <= link_word;
        @(posedge clk);
        shadow.write_reg(CFG_LINK_UP, link_word);
        cfg_index <= CFG_QUEUE_LIMIT;
        cfg_data  <= limit;
        @(posedge clk);
        shadow.write_reg(CFG_QUEUE_LIMIT, limit);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [LEN_W-1:0] random_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return LEN_W'($urandom_range(0, 80));
        else if (roll < 90)
            return LEN_W'($urandom_range(0, 300));
        else if (roll < 97)
            return LEN_W'($urandom_range(1519, 2047));
        else
            return LEN_W'($urandom);
    endfunction

    function automatic logic [UNITS_W-1:0] random_quanta();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            return '0;
        else if (roll < 85)
            return UNITS_W'($urandom_range(1, 3));
        else
            return UNITS_W'($urandom);
    endfunction

    // Tick through a short period such as the gap; a pause is cut short, a frame is ticked on.
    task automatic advance_to_boundary();
        int span;
        if (shadow.mode == MODE_PAUSE)
            send_item(FUNC_PAUSE, LEN_W'($urandom), UNITS_W'($urandom_range(0, 1)));
        else if (shadow.countdown <= 100)
        begin
            span = int'(shadow.countdown) + int'($urandom_range(0, 4)) - 2;
            send_ticks((span < 1) ? 1 : span);
        end
        else
            send_ticks($urandom_range(1, 6));
    endtask

    // Random traffic until the given number of further transfers has been made.
    task automatic run_random(input int count);
        int pick;
        int target;
        target = items_sent + count;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                send_ticks($urandom_range(1, 6));
            else if (pick < 42)
                advance_to_boundary();
            else if (pick < 68)
                send_item(FUNC_FRAME, random_length(), UNITS_W'($urandom));
            else if (pick < 88)
                send_item(FUNC_PAUSE, LEN_W'($urandom), random_quanta());
            else if (pick < 92)
                send_item(FUNC_UNUSED, LEN_W'($urandom), UNITS_W'($urandom));
            else
            begin
                // A burst of short frames to fill the queue.
                repeat ($urandom_range(2, 8))
                    send_item(FUNC_FRAME, LEN_W'($urandom_range(0, 80)), UNITS_W'($urandom));
            end
        end
    endtask

    task automatic run_directed();
        // Idle behavior, the unused code, and pauses while idle and while paused.
        send_item(FUNC_TICK, '0, '0);
        send_item(FUNC_UNUSED, '1, '1);
        send_item(FUNC_PAUSE, '1, '0);
        send_item(FUNC_PAUSE, '0, '1);
        send_item(FUNC_PAUSE, '0, 16'd1);
        // Frame lengths at the edges: padded while paused, and oversize.
        send_item(FUNC_FRAME, '0, '1);
        send_item(FUNC_FRAME, '1, '0);
        send_item(FUNC_FRAME, MAX_FRAME_BYTES + 1, '0);
        // A zero count resumes; counts while transmitting are held, replaced or canceled.
        send_item(FUNC_PAUSE, '0, '0);
        send_item(FUNC_PAUSE, '0, 16'd7);
        send_item(FUNC_PAUSE, '0, '0);
        send_item(FUNC_PAUSE, '0, 16'd2);
        send_item(FUNC_FRAME, 11'd64, '0);
        // The held pause takes over at the end of the frame; a zero count cuts it short.
        send_ticks(shadow.countdown);
        send_item(FUNC_PAUSE, '0, '0);
        send_item(FUNC_FRAME, 11'd100, '0);
        // The running frame ends into the gap, where a held pause takes over at the gap's end.
        send_ticks(shadow.countdown);
        send_item(FUNC_PAUSE, '0, 16'd3);
        send_ticks(shadow.countdown);
        send_item(FUNC_PAUSE, '0, '0);

        // Link down drops frames, after the oversize check.
        drain_reports();
        write_regs(1'b0, 5'd16);
        send_item(FUNC_FRAME, 11'd2000, '0);
        send_item(FUNC_FRAME, MAX_FRAME_BYTES, '0);
        // A queue of one frame, then a limit of zero.
        drain_reports();
        write_regs(1'b1, 5'd1);
        send_item(FUNC_FRAME, 11'd64, '0);
        send_item(FUNC_FRAME, 11'd64, '0);
        send_item(FUNC_FRAME, 11'd64, '0);
        drain_reports();
        write_regs(1'b1, 5'd0);
        send_item(FUNC_FRAME, 11'd70, '0);
    endtask

    // Receiver: random stalls, plus a long hold-off counted here when one is requested.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_hold_left > 0)
            begin
                m_tready <= 1'b0;
                rx_hold_left--;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Check every output transfer.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            shadow.check_report(m_tdata);
    end

    initial
    begin
        shadow = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int p = 0; p < 5; p++)
        begin
            drain_reports();
            write_regs(phase_link[p][0], COUNT_W'(phase_limit[p]));
            tx_idle_pct = phase_tx_idle[p];
            rx_stall_pct = phase_rx_stall[p];
            if (phase_hold[p] != 0)
            begin
                // The receiver holds off while the sender keeps offering transfers.
                rx_hold_left = 100;
            end
            run_random(phase_items[p]);
        end
        drain_reports();
        repeat (8) @(posedge clk);
        if (shadow.mismatch_count == 0 && shadow.pending_tx_reports.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #16000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/etpc_pkg.sv
design/etpc_queue.sv
design/etpc_ctrl.sv
design/etpc_skid.sv
design/ethernet_tx_pause_controller_unit.sv
tb/ethernet_tx_pause_controller_unit_tb.sv
